@@ rtl/lcaus_pkg.sv @@
`default_nettype none
package lcaus_pkg;

   // defaults of the top level parameters
   localparam int DEF_NUM_LEAVES  = 16;
   localparam int DEF_NUM_UPLINKS = 4;
   localparam int DEF_METRIC_BITS = 8;

   // fixed field widths of the header format
   localparam int LEAF_BITS  = 4;
   localparam int TAG_BITS   = 2;
   localparam int WIRE_METRIC_BITS = 8;

   // uplinks compared per cycle by the back end, unless a stalled output holds its last group
   localparam int SCAN_LANES = 4;

   // command queue between front and back, power of two
   localparam int QUEUE_DEPTH = 2;

   localparam logic ACTION_OUT = 1'b0;
   localparam logic ACTION_IN  = 1'b1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OWN_LEAF  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COIN_SEED = 2'd1;

   localparam logic [15:0] SEED_DEFAULT = 16'd44257;
   localparam logic [15:0] LFSR_TAPS    = 16'hB400;

   typedef struct packed {
      logic                        action;
      logic [LEAF_BITS-1:0]        peer_leaf;
      logic [TAG_BITS-1:0]         path_tag_in;
      logic [WIRE_METRIC_BITS-1:0] path_metric_in;
      logic [TAG_BITS-1:0]         feedback_tag_in;
      logic [WIRE_METRIC_BITS-1:0] feedback_metric_in;
   } req_type;

   typedef struct packed {
      logic [LEAF_BITS-1:0]        source_leaf;
      logic [LEAF_BITS-1:0]        dest_leaf;
      logic [TAG_BITS-1:0]         chosen_uplink;
      logic [WIRE_METRIC_BITS-1:0] path_metric_out;
      logic [TAG_BITS-1:0]         feedback_tag_out;
      logic [WIRE_METRIC_BITS-1:0] feedback_metric_out;
   } rsp_type;

   // classified item: leaf and tags already wrapped, metrics already saturated
   typedef struct packed {
      logic                        action;
      logic [LEAF_BITS-1:0]        leaf;
      logic [TAG_BITS-1:0]         tag;
      logic [WIRE_METRIC_BITS-1:0] metric;
      logic [TAG_BITS-1:0]         fb_tag;
      logic [WIRE_METRIC_BITS-1:0] fb_metric;
   } cmd_type;

   typedef struct packed {
      logic                    seed_load;
      logic [15:0]             seed;
      logic [LEAF_BITS-1:0]    own_leaf;
   } cfg_type;

   // value mod modulus for every 4-bit value, built at elaboration
   function automatic logic [15:0][3:0] wrap_table16(input int modulus);
      logic [15:0][3:0] tbl;
      int               r;
      tbl = '0;
      for (int v = 0; v < 16; v++) begin
         r = v;
         for (int k = 0; k < 16; k++) begin
            if (r >= modulus) begin
               r = r - modulus;
            end
         end
         tbl[v] = 4'(r);
      end
      return tbl;
   endfunction

endpackage
`default_nettype wire

@@ rtl/lcaus_front.sv @@
`default_nettype none
module lcaus_front #(
   parameter int NUM_LEAVES  = 16,
   parameter int NUM_UPLINKS = 4,
   parameter int METRIC_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lcaus_pkg::req_type req_data,
   output logic                   q_valid,
   output lcaus_pkg::cmd_type     q_head,
   input  wire logic              q_pop
);
   import lcaus_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [15:0][3:0] LEAF_WRAP = wrap_table16(NUM_LEAVES);
   localparam logic [15:0][3:0] TAG_WRAP  = wrap_table16(NUM_UPLINKS);
   localparam logic [WIRE_METRIC_BITS-1:0] METRIC_MAX =
      WIRE_METRIC_BITS'((1 << METRIC_BITS) - 1);

   cmd_type             cmd;
   logic [3:0]          tag_wrapped;
   logic [3:0]          fb_tag_wrapped;
   logic                push;
   logic                full;

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   // classify: wrap indexes, saturate metrics
   always_comb begin
      tag_wrapped    = TAG_WRAP[{2'b00, req_data.path_tag_in}];
      fb_tag_wrapped = TAG_WRAP[{2'b00, req_data.feedback_tag_in}];
      cmd.action     = req_data.action;
      cmd.leaf       = LEAF_WRAP[req_data.peer_leaf];
      cmd.tag        = tag_wrapped[TAG_BITS-1:0];
      cmd.fb_tag     = fb_tag_wrapped[TAG_BITS-1:0];
      cmd.metric     = (req_data.path_metric_in > METRIC_MAX) ?
                       METRIC_MAX : req_data.path_metric_in;
      cmd.fb_metric  = (req_data.feedback_metric_in > METRIC_MAX) ?
                       METRIC_MAX : req_data.feedback_metric_in;
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign req_stall = full;
   assign push      = req_valid && !full;
   assign q_valid   = (count_ff != '0);
   assign q_head    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lcaus_back.sv @@
`default_nettype none
module lcaus_back #(
   parameter int NUM_LEAVES  = 16,
   parameter int NUM_UPLINKS = 4,
   parameter int METRIC_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lcaus_pkg::cfg_type cfg,
   input  wire logic               q_valid,
   input  wire lcaus_pkg::cmd_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output lcaus_pkg::rsp_type      rsp_data
);
   import lcaus_pkg::*;

   localparam int LEAF_W     = $clog2(NUM_LEAVES);
   localparam int UP_W       = $clog2(NUM_UPLINKS);
   localparam int MB         = METRIC_BITS;
   localparam int NUM_CHUNKS = (NUM_UPLINKS + SCAN_LANES - 1) / SCAN_LANES;
   localparam int PAD_LANES  = NUM_CHUNKS * SCAN_LANES;
   localparam int IDX_W      = $clog2(PAD_LANES);
   localparam int ROW_W      = NUM_UPLINKS * MB;
   localparam int PAD_W      = PAD_LANES * MB;
   localparam int LAST_BASE  = PAD_LANES - SCAN_LANES;

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_SCAN = 1'b1;

   // tables, one row per leaf
   logic [ROW_W-1:0]      to_mem   [NUM_LEAVES];
   logic [ROW_W-1:0]      from_mem [NUM_LEAVES];
   logic [UP_W-1:0]       ptr_mem  [NUM_LEAVES];

   logic [NUM_LEAVES-1:0] to_vld_ff, to_vld_in;
   logic [NUM_LEAVES-1:0] from_vld_ff, from_vld_in;
   logic [NUM_LEAVES-1:0] ptr_vld_ff, ptr_vld_in;

   logic [0:0]            state_ff, state_in;
   logic [IDX_W-1:0]      base_ff, base_in;
   logic [15:0]           lfsr_ff, lfsr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [ROW_W-1:0]      to_rd_ff;
   logic [ROW_W-1:0]      from_rd_ff;
   logic [UP_W-1:0]       ptr_rd_ff;
   logic                  to_rd_vld_ff, from_rd_vld_ff, ptr_rd_vld_ff;
   logic [LEAF_BITS-1:0]  cur_leaf_ff;
   logic [PAD_W-1:0]      work_ff, work_in;
   logic [MB-1:0]         best_val_ff, best_val_in;
   logic [UP_W-1:0]       best_idx_ff, best_idx_in;

   logic                  pop;
   logic                  arrive;
   logic                  depart;
   logic [LEAF_W-1:0]     head_leaf;
   logic [LEAF_W-1:0]     cur_leaf;
   logic [UP_W-1:0]       head_tag;
   logic [UP_W-1:0]       head_fb_tag;

   logic [NUM_UPLINKS-1:0] to_lane_en, from_lane_en;
   logic [ROW_W-1:0]      to_wdata, from_wdata;
   logic                  ptr_we;
   logic [LEAF_W-1:0]     ptr_addr;
   logic [UP_W-1:0]       ptr_wdata;

   logic [ROW_W-1:0]      to_row, from_row;
   logic [UP_W-1:0]       ptr_cur, ptr_next;
   logic [MB-1:0]         fb_val;
   logic                  chunk0;
   logic                  last;
   logic                  out_free;
   logic                  advance;
   logic                  finish;
   logic [PAD_W-1:0]      work_src;
   logic [15:0]           scan_lfsr;
   logic [MB-1:0]         scan_val;
   logic [UP_W-1:0]       scan_idx;
   logic [IDX_W-1:0]      idx;
   logic [MB-1:0]         lane_val;
   logic                  coin;

   assign pop         = (state_ff == ST_IDLE) && q_valid;
   assign arrive      = pop && (q_head.action == ACTION_IN);
   assign depart      = pop && (q_head.action == ACTION_OUT);
   assign q_pop       = pop;
   assign head_leaf   = LEAF_W'(q_head.leaf);
   assign cur_leaf    = LEAF_W'(cur_leaf_ff);
   assign head_tag    = UP_W'(q_head.tag);
   assign head_fb_tag = UP_W'(q_head.fb_tag);

   // a first write to a row that was never written fills the rest with zero
   always_comb begin
      to_wdata   = '0;
      from_wdata = '0;
      to_wdata[head_fb_tag*MB +: MB] = MB'(q_head.fb_metric);
      from_wdata[head_tag*MB +: MB]  = MB'(q_head.metric);
      to_lane_en   = '0;
      from_lane_en = '0;
      if (arrive) begin
         if (to_vld_ff[head_leaf]) begin
            to_lane_en[head_fb_tag] = 1'b1;
         end else begin
            to_lane_en = '1;
         end
         if (from_vld_ff[head_leaf]) begin
            from_lane_en[head_tag] = 1'b1;
         end else begin
            from_lane_en = '1;
         end
      end
   end

   always_comb begin
      to_row   = to_rd_vld_ff ? to_rd_ff : '0;
      from_row = from_rd_vld_ff ? from_rd_ff : '0;
      ptr_cur  = ptr_rd_vld_ff ? ptr_rd_ff : '0;
      fb_val   = from_row[ptr_cur*MB +: MB];
      ptr_next = (ptr_cur == UP_W'(NUM_UPLINKS - 1)) ? '0 : ptr_cur + UP_W'(1);
   end

   // scan one group of uplinks; equal metrics are settled by the coin bit
   always_comb begin
      chunk0    = (base_ff == '0);
      work_src  = chunk0 ? PAD_W'(to_row) : work_ff;
      scan_val  = chunk0 ? work_src[MB-1:0] : best_val_ff;
      scan_idx  = chunk0 ? '0 : best_idx_ff;
      scan_lfsr = lfsr_ff;
      idx       = '0;
      lane_val  = '0;
      coin      = 1'b0;
      for (int j = 0; j < SCAN_LANES; j++) begin
         idx      = base_ff + IDX_W'(j);
         lane_val = work_src[j*MB +: MB];
         if ((idx != '0) && (int'(idx) < NUM_UPLINKS)) begin
            if (lane_val == scan_val) begin
               coin      = scan_lfsr[0];
               scan_lfsr = (scan_lfsr >> 1) ^ (coin ? LFSR_TAPS : 16'h0000);
               if (coin) begin
                  scan_idx = UP_W'(idx);
               end
            end else if (lane_val < scan_val) begin
               scan_val = lane_val;
               scan_idx = UP_W'(idx);
            end
         end
      end
      work_in = work_src >> (SCAN_LANES * MB);
   end

   assign last     = (base_ff == IDX_W'(LAST_BASE));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = (state_ff == ST_SCAN) && (!last || out_free);
   assign finish   = (state_ff == ST_SCAN) && last && out_free;

   always_comb begin
      ptr_we    = arrive || finish;
      ptr_addr  = arrive ? head_leaf : cur_leaf;
      ptr_wdata = arrive ? head_tag : ptr_next;

      to_vld_in   = to_vld_ff;
      from_vld_in = from_vld_ff;
      ptr_vld_in  = ptr_vld_ff;
      if (arrive) begin
         to_vld_in[head_leaf]   = 1'b1;
         from_vld_in[head_leaf] = 1'b1;
      end
      if (ptr_we) begin
         ptr_vld_in[ptr_addr] = 1'b1;
      end

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (depart) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      base_in = base_ff;
      if (depart || finish) begin
         base_in = '0;
      end else if (advance) begin
         base_in = base_ff + IDX_W'(SCAN_LANES);
      end

      if (cfg.seed_load) begin
         lfsr_in = (cfg.seed == '0) ? SEED_DEFAULT : cfg.seed;
      end else if (advance) begin
         lfsr_in = scan_lfsr;
      end else begin
         lfsr_in = lfsr_ff;
      end

      best_val_in = advance ? scan_val : best_val_ff;
      best_idx_in = advance ? scan_idx : best_idx_ff;

      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in = rsp_data_ff;
      if (finish) begin
         rsp_data_in.source_leaf         = cfg.own_leaf;
         rsp_data_in.dest_leaf           = cur_leaf_ff;
         rsp_data_in.chosen_uplink       = TAG_BITS'(scan_idx);
         rsp_data_in.path_metric_out     = '0;
         rsp_data_in.feedback_tag_out    = TAG_BITS'(ptr_cur);
         rsp_data_in.feedback_metric_out = WIRE_METRIC_BITS'(fb_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         lfsr_ff      <= SEED_DEFAULT;
         rsp_valid_ff <= 1'b0;
         to_vld_ff    <= '0;
         from_vld_ff  <= '0;
         ptr_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
         to_vld_ff    <= to_vld_in;
         from_vld_ff  <= from_vld_in;
         ptr_vld_ff   <= ptr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      if (advance) begin
         work_ff <= work_in;
      end
      if (depart) begin
         cur_leaf_ff    <= q_head.leaf;
         to_rd_vld_ff   <= to_vld_ff[head_leaf];
         from_rd_vld_ff <= from_vld_ff[head_leaf];
         ptr_rd_vld_ff  <= ptr_vld_ff[head_leaf];
      end
   end

   // table memories: lane-enabled row write, registered row read
   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_UPLINKS; l++) begin
         if (to_lane_en[l]) begin
            to_mem[head_leaf][l*MB +: MB] <= to_wdata[l*MB +: MB];
         end
         if (from_lane_en[l]) begin
            from_mem[head_leaf][l*MB +: MB] <= from_wdata[l*MB +: MB];
         end
      end
      if (depart) begin
         to_rd_ff   <= to_mem[head_leaf];
         from_rd_ff <= from_mem[head_leaf];
      end
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_addr] <= ptr_wdata;
      end
      if (depart) begin
         ptr_rd_ff <= ptr_mem[head_leaf];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/leaf_congestion_aware_uplink_select.sv @@
// Leaf uplink selector with congestion feedback.
// req channel: one packet header per item. An outgoing item (action 0) asks
// for the least congested uplink toward peer_leaf and gives exactly one rsp
// item; an arriving item (action 1) updates the tables for peer_leaf and
// gives no rsp item.
// csr port: index 0 sets own_leaf_id, index 1 loads the tie-break LFSR seed
// (zero means the default seed). Write only while no item is in flight.
// For an outgoing item the back end first does a registered row read, then
// compares the uplinks in groups of four in the compare chain and registers
// the result for rsp; it takes no new item until that scan is done. An
// arriving item only updates the tables, and the back end stays ready for
// the next item.
// A two-entry queue sits between the classifying front end and the back end.
// Reset: tables read as zero through per-row valid bits, no clearing pass;
// feedback pointers read as zero; the LFSR starts from 44257.
// rsp_stall: the result stays in the output register, the back end waits at
// the end of its scan, the queue fills and then req_stall rises.
`default_nettype none
module leaf_congestion_aware_uplink_select #(
   parameter int NUM_LEAVES  = lcaus_pkg::DEF_NUM_LEAVES,
   parameter int NUM_UPLINKS = lcaus_pkg::DEF_NUM_UPLINKS,
   parameter int METRIC_BITS = lcaus_pkg::DEF_METRIC_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire lcaus_pkg::req_type                      req_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output lcaus_pkg::rsp_type                           rsp_data,
   input  wire logic                                    csr_wr_en,
   input  wire logic [lcaus_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [lcaus_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import lcaus_pkg::*;

   logic [LEAF_BITS-1:0] own_leaf_ff, own_leaf_in;
   cfg_type              cfg;
   logic                 q_valid;
   logic                 q_pop;
   cmd_type              q_head;

   always_comb begin
      own_leaf_in = own_leaf_ff;
      if (csr_wr_en && (csr_index == CSR_OWN_LEAF)) begin
         own_leaf_in = csr_wdata[LEAF_BITS-1:0];
      end
      cfg.seed_load = csr_wr_en && (csr_index == CSR_COIN_SEED);
      cfg.seed      = csr_wdata[15:0];
      cfg.own_leaf  = own_leaf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_leaf_ff <= '0;
      end else begin
         own_leaf_ff <= own_leaf_in;
      end
   end

   lcaus_front #(
      .NUM_LEAVES  (NUM_LEAVES),
      .NUM_UPLINKS (NUM_UPLINKS),
      .METRIC_BITS (METRIC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   lcaus_back #(
      .NUM_LEAVES  (NUM_LEAVES),
      .NUM_UPLINKS (NUM_UPLINKS),
      .METRIC_BITS (METRIC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // no result survives a reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // result indexes stay inside the configured table
   a_rsp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_data.chosen_uplink) < NUM_UPLINKS) &&
                    (int'(rsp_data.feedback_tag_out) < NUM_UPLINKS) &&
                    (int'(rsp_data.dest_leaf) < NUM_LEAVES))
      else $error("result index out of range");

   // back end only takes an item the queue holds
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // new results only come from the back end finishing a scan
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(q_pop))
      else $error("result appeared in the cycle after a pop");

endmodule
`default_nettype wire

@@ sim/tb_leaf_congestion_aware_uplink_select.sv @@
`timescale 1ns / 100ps
module tb_leaf_congestion_aware_uplink_select;
   import lcaus_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   // indexes past the last register, writes to them must change nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // copy of the block state
   logic [WIRE_METRIC_BITS-1:0] to_leaf_m [DEF_NUM_LEAVES][DEF_NUM_UPLINKS];
   logic [WIRE_METRIC_BITS-1:0] from_leaf_m [DEF_NUM_LEAVES][DEF_NUM_UPLINKS];
   logic [TAG_BITS-1:0] fb_pointer_m [DEF_NUM_LEAVES];
   logic [15:0] coin_state;
   logic [LEAF_BITS-1:0] own_leaf_m;

   rsp_type pending_headers[$];
   int mismatches = 0;
   int cycle_count = 0;
   bit steady = 1'b0;
   int stall_left = 0;

   leaf_congestion_aware_uplink_select dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic bit next_coin();
      bit b;
      b = coin_state[0];
      coin_state = coin_state >> 1;
      if (b) begin
         coin_state = coin_state ^ LFSR_TAPS;
      end
      return b;
   endfunction

   // update the tables for one accepted item, queue the header it produces
   task automatic predict_uplink(input req_type it);
      rsp_type hdr;
      logic [LEAF_BITS-1:0] leaf;
      logic [TAG_BITS-1:0] best;
      logic [WIRE_METRIC_BITS-1:0] best_val;
      logic [WIRE_METRIC_BITS-1:0] v;
      leaf = it.peer_leaf;
      if (it.action == ACTION_IN) begin
         to_leaf_m[leaf][it.feedback_tag_in] = it.feedback_metric_in;
         from_leaf_m[leaf][it.path_tag_in] = it.path_metric_in;
         fb_pointer_m[leaf] = it.path_tag_in;
      end else begin
         best = '0;
         best_val = to_leaf_m[leaf][0];
         for (int i = 1; i < DEF_NUM_UPLINKS; i++) begin
            v = to_leaf_m[leaf][i];
            if (v == best_val) begin
               if (next_coin()) begin
                  best = TAG_BITS'(i);
               end
            end else if (v < best_val) begin
               best = TAG_BITS'(i);
               best_val = v;
            end
         end
         hdr.source_leaf = own_leaf_m;
         hdr.dest_leaf = leaf;
         hdr.chosen_uplink = best;
         hdr.path_metric_out = '0;
         hdr.feedback_tag_out = fb_pointer_m[leaf];
         hdr.feedback_metric_out = from_leaf_m[leaf][fb_pointer_m[leaf]];
         fb_pointer_m[leaf] = fb_pointer_m[leaf] + 1'b1;
         pending_headers = {pending_headers, hdr};
      end
   endtask

   task automatic clear_model();
      for (int l = 0; l < DEF_NUM_LEAVES; l++) begin
         fb_pointer_m[l] = '0;
         for (int u = 0; u < DEF_NUM_UPLINKS; u++) begin
            to_leaf_m[l][u] = '0;
            from_leaf_m[l][u] = '0;
         end
      end
      own_leaf_m = '0;
      coin_state = SEED_DEFAULT;
   endtask

   task automatic send_item(input req_type it);
      int gap;
      gap = (!steady && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      predict_uplink(it);
   endtask

   // stop sending, wait for every header, then let the back end go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_headers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_OWN_LEAF) begin
         own_leaf_m = val[LEAF_BITS-1:0];
      end else if (idx == CSR_COIN_SEED) begin
         coin_state = (val != '0) ? val : SEED_DEFAULT;
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_metric();
      // small values make ties common
      return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
   endfunction

   function automatic req_type arriving(input int leaf, input int tag, input int metric,
                                        input int fb_tag, input int fb_metric);
      req_type it;
      it.action = ACTION_IN;
      it.peer_leaf = LEAF_BITS'(leaf);
      it.path_tag_in = TAG_BITS'(tag);
      it.path_metric_in = 8'(metric);
      it.feedback_tag_in = TAG_BITS'(fb_tag);
      it.feedback_metric_in = 8'(fb_metric);
      return it;
   endfunction

   // unused fields of an outgoing item carry random bits
   function automatic req_type outgoing(input int leaf);
      req_type it;
      it = req_type'($urandom);
      it.action = ACTION_OUT;
      it.peer_leaf = LEAF_BITS'(leaf);
      return it;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned got_v);
      if (exp_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_hdr;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_headers.size() == 0) begin
            $error("rsp item with no header pending: %h", rsp_data);
            mismatches++;
         end else begin
            exp_hdr = pending_headers.pop_front();
            check_field("source_leaf", exp_hdr.source_leaf, rsp_data.source_leaf);
            check_field("dest_leaf", exp_hdr.dest_leaf, rsp_data.dest_leaf);
            check_field("chosen_uplink", exp_hdr.chosen_uplink, rsp_data.chosen_uplink);
            check_field("path_metric_out", exp_hdr.path_metric_out,
                        rsp_data.path_metric_out);
            check_field("feedback_tag_out", exp_hdr.feedback_tag_out,
                        rsp_data.feedback_tag_out);
            check_field("feedback_metric_out", exp_hdr.feedback_metric_out,
                        rsp_data.feedback_metric_out);
         end
      end
   end

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (reset || steady) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_reset_defaults();
      // empty tables: every uplink ties, pointer starts at zero and advances
      send_item(outgoing(0));
      send_item(outgoing(15));
      send_item(outgoing(0));
   endtask

   task automatic test_field_extremes();
      send_item(arriving(15, 3, 255, 3, 255));
      send_item(arriving(15, 0, 0, 0, 0));
      send_item(outgoing(15));
   endtask

   task automatic test_strict_minimum();
      send_item(arriving(3, 1, 200, 0, 200));
      send_item(arriving(3, 2, 150, 1, 150));
      send_item(arriving(3, 0, 17, 2, 100));
      send_item(arriving(3, 3, 90, 3, 7));
      send_item(outgoing(3));
   endtask

   task automatic test_full_tie();
      for (int u = 0; u < DEF_NUM_UPLINKS; u++) begin
         send_item(arriving(4, u, 40 + u, u, 9));
      end
      send_item(outgoing(4));
      send_item(outgoing(4));
   endtask

   task automatic test_csr_settings();
      settle();
      write_csr(CSR_OWN_LEAF, 16'h000F);
      write_csr(CSR_COIN_SEED, 16'h0000);   // zero seed falls back to the default
      send_item(outgoing(4));
      settle();
      write_csr(CSR_OWN_LEAF, 16'hFFF0);    // upper bits dropped
      write_csr(CSR_COIN_SEED, 16'hFFFF);
      send_item(outgoing(4));
      settle();
      write_csr(CSR_COIN_SEED, 16'h0001);
      write_csr(CSR_SPARE_A, 16'hFFFF);
      write_csr(CSR_SPARE_B, 16'h5A5A);
      send_item(outgoing(4));
      send_item(outgoing(7));
   endtask

   task automatic test_random_traffic(input int count, input logic [LEAF_BITS-1:0] own,
                                      input logic [15:0] seed, input bit calm);
      int sent;
      int leaf;
      int metric;
      req_type it;
      settle();
      write_csr(CSR_OWN_LEAF, 16'(own));
      write_csr(CSR_COIN_SEED, seed);
      steady = calm;
      sent = 0;
      while (sent < count) begin
         leaf = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
         if ($urandom_range(0, 9) < 2) begin
            // refresh a whole row to one value, then route over it
            metric = pick_metric();
            for (int u = 0; u < DEF_NUM_UPLINKS; u++) begin
               send_item(arriving(leaf, $urandom_range(0, 3), pick_metric(), u, metric));
            end
            send_item(outgoing(leaf));
            sent += 5;
         end else begin
            it = req_type'($urandom);
            it.peer_leaf = LEAF_BITS'(leaf);
            it.path_metric_in = pick_metric();
            it.feedback_metric_in = pick_metric();
            send_item(it);
            sent++;
         end
      end
   endtask

   initial begin
      clear_model();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_field_extremes();
      test_strict_minimum();
      test_full_tie();
      test_csr_settings();
      test_random_traffic(300, 4'd5, 16'($urandom_range(1, 65535)), 1'b0);
      test_random_traffic(300, 4'd15, 16'hFFFF, 1'b0);
      test_random_traffic(300, 4'd0, 16'h0001, 1'b0);
      test_random_traffic(250, 4'($urandom), 16'h0000, 1'b1);
      settle();
      if (mismatches == 0) begin
         $display("tb_leaf_congestion_aware_uplink_select: PASS");
      end else begin
         $display("tb_leaf_congestion_aware_uplink_select: FAIL");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_leaf_congestion_aware_uplink_select: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/lcaus_pkg.sv
rtl/lcaus_front.sv
rtl/lcaus_back.sv
rtl/leaf_congestion_aware_uplink_select.sv
sim/tb_leaf_congestion_aware_uplink_select.sv
